### sv/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg: shared definitions for the Galois field ALU
// Field width default, register reset value, field widths and command codes.
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam int FieldBitsDefault = 8;

  localparam int CmdW  = 2;
  localparam int OpW   = 8;
  localparam int ExpW  = 16;
  localparam int ResW  = 8;
  localparam int PolyW = 9;

  localparam logic [PolyW-1:0] PolyReset = 9'd285;

  typedef enum logic [CmdW-1:0] {
    CMD_XOR = 2'd0,
    CMD_MUL = 2'd1,
    CMD_DIV = 2'd2,
    CMD_POW = 2'd3
  } cmd_e;

endpackage

### sv/gfa_in_if.sv
// ----------------------------------------------------------------------------
// gfa_in_if: command channel of the Galois field ALU
// Valid/ready channel carrying the command, both operands and the exponent.
// ----------------------------------------------------------------------------
interface gfa_in_if;
  import gfa_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [OpW-1:0]  operand_a;
  logic [OpW-1:0]  operand_b;
  logic [ExpW-1:0] exponent;

  modport source (output valid, command, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, command, operand_a, operand_b, exponent, output ready);

endinterface

### sv/gfa_out_if.sv
// ----------------------------------------------------------------------------
// gfa_out_if: result channel of the Galois field ALU
// Valid/ready channel carrying the result element and the divide-by-zero flag.
// ----------------------------------------------------------------------------
interface gfa_out_if;
  import gfa_pkg::*;

  logic            valid;
  logic            ready;
  logic [ResW-1:0] result;
  logic            divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);

endinterface

### sv/galois_field_alu.sv
// ----------------------------------------------------------------------------
// galois_field_alu: arithmetic unit for GF(2^m) elements
// Add, multiply, divide and power on one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command transaction (command, operand_a, operand_b,
//   exponent); out_o returns one result transaction (result, divide_by_zero)
//   per command, in order. The field polynomial is written on cfg_we_i /
//   cfg_wdata_i; the user must do so while the unit is idle, as the block
//   does not enforce it; reset loads 285. One command is processed at a
//   time; in_i.ready is high only when idle. Field multiplications run on
//   the bit-serial multiplier; the commands use it as follows:
//     add:      XOR of the operands, no multiply
//     multiply: one field multiply
//     power:    16 squarings plus one multiply per set exponent bit,
//               at most 32 multiplies in all
//     divide:   power by 2^FIELD_BITS - 2 and a final multiply;
//               divide by zero returns without a multiply, with a zero
//               result and the flag set
//   The result sits in an output register, so a new command is accepted
//   while a result waits. If the receiver stalls, a finished result holds
//   until the output register frees. Reset clears the state, start and valid flags.
// ----------------------------------------------------------------------------
module galois_field_alu #(
  parameter int FIELD_BITS = gfa_pkg::FieldBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gfa_pkg::PolyW-1:0] cfg_wdata_i,
  gfa_in_if.sink                    in_i,
  gfa_out_if.source                 out_o
);
  import gfa_pkg::*;

  localparam int DivExp = (1 << FIELD_BITS) - 2;
  localparam logic [ExpW-1:0] DivExpBits = ExpW'(DivExp);
  localparam logic [FIELD_BITS-1:0] ElemOne = FIELD_BITS'(1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SQR   = 5'b00010,
    ST_MULB  = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic                  start_q, start_d;
  logic                  ovalid_q, ovalid_d;
  logic [PolyW-1:0]      poly_q;
  cmd_e                  cmd_q, cmd_d;
  logic [FIELD_BITS-1:0] a_q, a_d;
  logic [FIELD_BITS-1:0] acc_q, acc_d;
  logic [FIELD_BITS-1:0] base_q, base_d;
  logic [FIELD_BITS-1:0] res_q, res_d;
  logic                  dz_q, dz_d;
  logic [ExpW-1:0]       exp_q, exp_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [ResW-1:0]       ores_q, ores_d;
  logic                  odz_q, odz_d;

  logic [FIELD_BITS-1:0] elem_a, elem_b;
  logic [FIELD_BITS-1:0] mul_x, mul_y, mul_p, taps;
  logic                  mul_done;
  logic                  bit_done;

  assign elem_a = FIELD_BITS'(in_i.operand_a);
  assign elem_b = FIELD_BITS'(in_i.operand_b);
  assign taps   = FIELD_BITS'(poly_q);

  assign mul_x = (state_q == ST_FINAL) ? a_q : acc_q;
  assign mul_y = (state_q == ST_MULB) ? base_q : acc_q;

  gfa_mul #(
    .FIELD_BITS(FIELD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .a_i    (mul_x),
    .b_i    (mul_y),
    .taps_i (taps),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign bit_done = mul_done &&
                    (((state_q == ST_SQR) && !exp_q[ExpW-1]) || (state_q == ST_MULB));

  always_comb begin
    state_d  = state_q;
    start_d  = 1'b0;
    ovalid_d = ovalid_q;
    cmd_d    = cmd_q;
    a_d      = a_q;
    acc_d    = acc_q;
    base_d   = base_q;
    res_d    = res_q;
    dz_d     = dz_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    ores_d   = ores_q;
    odz_d    = odz_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d = cmd_e'(in_i.command);
          a_d   = elem_a;
          acc_d = ElemOne;
          cnt_d = 4'd15;
          dz_d  = 1'b0;
          case (cmd_e'(in_i.command))
            CMD_XOR: begin
              res_d   = elem_a ^ elem_b;
              state_d = ST_OUT;
            end
            CMD_MUL: begin
              acc_d   = elem_b;
              start_d = 1'b1;
              state_d = ST_FINAL;
            end
            CMD_DIV: begin
              if (elem_b == '0) begin
                res_d   = '0;
                dz_d    = 1'b1;
                state_d = ST_OUT;
              end else begin
                base_d  = elem_b;
                exp_d   = DivExpBits;
                start_d = 1'b1;
                state_d = ST_SQR;
              end
            end
            CMD_POW: begin
              base_d  = elem_a;
              exp_d   = in_i.exponent;
              start_d = 1'b1;
              state_d = ST_SQR;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          acc_d = mul_p;
          if (exp_q[ExpW-1]) begin
            start_d = 1'b1;
            state_d = ST_MULB;
          end
        end
      end
      ST_MULB: begin
        if (mul_done) begin
          acc_d = mul_p;
        end
      end
      ST_FINAL: begin
        if (mul_done) begin
          res_d   = mul_p;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          ores_d   = ResW'(res_q);
          odz_d    = dz_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance to the next exponent bit, or leave the power loop
    if (bit_done) begin
      if (cnt_q == 4'd0) begin
        if (cmd_q == CMD_DIV) begin
          start_d = 1'b1;
          state_d = ST_FINAL;
        end else begin
          res_d   = mul_p;
          state_d = ST_OUT;
        end
      end else begin
        cnt_d   = cnt_q - 4'd1;
        exp_d   = {exp_q[ExpW-2:0], 1'b0};
        start_d = 1'b1;
        state_d = ST_SQR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
      poly_q   <= PolyReset;
    end else begin
      state_q  <= state_d;
      start_q  <= start_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    res_q  <= res_d;
    dz_q   <= dz_d;
    exp_q  <= exp_d;
    cnt_q  <= cnt_d;
    ores_q <= ores_d;
    odz_q  <= odz_d;
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = ovalid_q;
  assign out_o.result         = ores_q;
  assign out_o.divide_by_zero = odz_q;

endmodule

### sv/gfa_mul.sv
// ----------------------------------------------------------------------------
// gfa_mul: bit-serial GF(2^m) multiplier
// Consumes the multiplier one bit per cycle, MSB first, reducing the
// partial product by the field taps at each step. done_o is high for a single
// cycle once the last step is registered, with the product on p_o.
// ----------------------------------------------------------------------------
module gfa_mul #(
  parameter int FIELD_BITS = gfa_pkg::FieldBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] b_i,
  input  logic [FIELD_BITS-1:0] taps_i,
  output logic                  done_o,
  output logic [FIELD_BITS-1:0] p_o
);
  import gfa_pkg::*;

  localparam int CntW = $clog2(FIELD_BITS + 1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [FIELD_BITS-1:0] x_q, y_q, p_q;
  logic [FIELD_BITS-1:0] shifted, step;

  // multiply by x and reduce, then add the multiplicand on a set bit
  assign shifted = {p_q[FIELD_BITS-2:0], 1'b0} ^ (p_q[FIELD_BITS-1] ? taps_i : '0);
  assign step    = y_q[FIELD_BITS-1] ? (shifted ^ x_q) : shifted;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CntW'(FIELD_BITS);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= a_i;
      y_q <= b_i;
      p_q <= '0;
    end else if (cnt_q != '0) begin
      p_q <= step;
      y_q <= {y_q[FIELD_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule
